// ===== design/rlcm_pkg.sv =====
package rlcm_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int NUM_LISTS  = 4;

  localparam int NUM_CNT   = 4;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int SEL_W  = 2;
  localparam int EIDX_W = 8;
  localparam int CP_W   = 21;
  localparam int WORD_W = CP_W + 1;

  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int N_W        = IDX_W + 1;
  localparam int MEM_DEPTH  = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int NUM_LEVELS = IDX_W;
  localparam int MARK_BIT   = CP_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [N_W-1:0]    cnt_n_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  valid;
    logic  is_query;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_word;
    cp_t   cp;
    logic  inv;
    logic  done;
    logic  res;
    idx_t  lo;
    idx_t  hi;
    idx_t  mid;
    addr_t base;
  } item_t;

endpackage

// ===== design/rlcm_in_if.sv =====
interface rlcm_in_if;
  import rlcm_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SEL_W-1:0]    list_select;
  logic [EIDX_W-1:0]   entry_index;
  logic [CP_W-1:0]     code_point;
  logic                range_start;
  logic                invert;

  modport source (
    output valid, opcode, list_select, entry_index, code_point, range_start, invert,
    input  ready
  );

  modport sink (
    input  valid, opcode, list_select, entry_index, code_point, range_start, invert,
    output ready
  );
endinterface

// ===== design/rlcm_out_if.sv =====
interface rlcm_out_if;
  logic valid;
  logic ready;
  logic is_member;

  modport source (
    output valid, is_member,
    input  ready
  );

  modport sink (
    input  valid, is_member,
    output ready
  );
endinterface

// ===== design/range_list_class_membership_core.sv =====
// Character class membership over sorted range lists.
// Input channel in_ch carries one item per transfer: opcode write stores one
// list entry (code point plus range-start mark), opcode query tests a code
// point against the selected list and may invert the answer. Writes give no
// result; every query gives one is_member transfer on out_ch, in order.
// cfg_we/cfg_index/cfg_data set the entry count of each list; write them only
// while no item is in flight.
// A query passes the bounds stage, 8 search levels and the output register in
// turn. One item enters per cycle unless out_ch stalls.
// The binary search is unrolled one level per stage; each stage owns a copy of
// the entry store that a write updates as it passes, so queries and writes stay
// in order. Each copy is read at two addresses per cycle.
// Reset clears the counts and the pipeline valid bits; the entry store is not
// cleared and must be written before it is queried.
// When out_ch stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
module range_list_class_membership_core (
  input  logic                     clk,
  input  logic                     rst_n,
  rlcm_in_if.sink                  in_ch,
  rlcm_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [rlcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlcm_pkg::CNT_W-1:0]     cfg_data
);
  import rlcm_pkg::*;

  logic [CNT_W-1:0] cnt_r [NUM_CNT];

  logic       adv;
  logic       list_ok;
  logic       idx_ok;
  cnt_n_t     n_in;
  idx_t       last_in;
  addr_t      base_in;
  item_t      s0_nxt;

  word_t      mem0 [MEM_DEPTH];
  item_t      s0_r;
  cnt_n_t     n0_r;
  logic       ok0_r;
  word_t      first_r;
  word_t      last_r;
  cnt_n_t     n0_m1;
  cp_t        first_cp;
  cp_t        last_cp;

  item_t      lvl [NUM_LEVELS+1];
  item_t      fin;
  logic       out_valid_r;
  logic       is_member_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '{default: '0};
    end else if (cfg_we) begin
      cnt_r[cfg_index] <= cfg_data;
    end
  end

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign list_ok = int'(in_ch.list_select) < NUM_LISTS;
  assign idx_ok  = int'(in_ch.entry_index) < LIST_DEPTH;
  assign n_in    = (int'(cnt_r[in_ch.list_select]) > LIST_DEPTH) ? N_W'(LIST_DEPTH)
                                                                 : N_W'(cnt_r[in_ch.list_select]);
  assign last_in = IDX_W'(n_in - N_W'(1));
  assign base_in = ADDR_W'(int'(in_ch.list_select) * LIST_DEPTH);

  always_comb begin
    s0_nxt          = '0;
    s0_nxt.valid    = in_ch.valid;
    s0_nxt.is_query = (in_ch.opcode == OP_QUERY);
    s0_nxt.wr_en    = (in_ch.opcode == OP_WRITE) && list_ok && idx_ok;
    s0_nxt.wr_addr  = base_in + ADDR_W'(IDX_W'(in_ch.entry_index));
    s0_nxt.wr_word  = {in_ch.range_start, in_ch.code_point};
    s0_nxt.cp       = in_ch.code_point;
    s0_nxt.inv      = in_ch.invert;
    s0_nxt.base     = base_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s0_nxt.valid && s0_nxt.wr_en) begin
        mem0[s0_nxt.wr_addr] <= s0_nxt.wr_word;
      end
      first_r <= mem0[base_in];
      last_r  <= mem0[base_in + ADDR_W'(last_in)];
      n0_r    <= n_in;
      ok0_r   <= list_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
    end else if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  // settle the ends of the list before the search levels
  assign n0_m1    = n0_r - N_W'(1);
  assign first_cp = first_r[CP_W-1:0];
  assign last_cp  = last_r[CP_W-1:0];

  always_comb begin
    lvl[0]     = s0_r;
    lvl[0].lo  = '0;
    lvl[0].hi  = n0_m1[IDX_W-1:0];
    lvl[0].mid = n0_m1[IDX_W:1];
    if (s0_r.valid && s0_r.is_query) begin
      if (!ok0_r || n0_r == '0) begin
        lvl[0].done = 1'b1;
        lvl[0].res  = 1'b0;
      end else if (s0_r.cp <= first_cp) begin
        lvl[0].done = 1'b1;
        lvl[0].res  = (s0_r.cp == first_cp);
      end else if (s0_r.cp >= last_cp) begin
        lvl[0].done = 1'b1;
        lvl[0].res  = (s0_r.cp == last_cp);
      end
    end
  end

  for (genvar k = 0; k < NUM_LEVELS; k++) begin : g_level
    rlcm_level u_level (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .item_i (lvl[k]),
      .item_o (lvl[k+1])
    );
  end

  assign fin = lvl[NUM_LEVELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid && fin.is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_member_r <= (fin.done && fin.res) ^ fin.inv;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_member = is_member_r;
endmodule

// ===== design/rlcm_level.sv =====
module rlcm_level (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  rlcm_pkg::item_t item_i,
  output rlcm_pkg::item_t item_o
);
  import rlcm_pkg::*;

  localparam int MID_W = IDX_W + 1;

  word_t            mem [MEM_DEPTH];
  item_t            item_r;
  word_t            rd0_r;
  word_t            rd1_r;
  addr_t            rd_addr0;
  addr_t            rd_addr1;
  logic [MID_W-1:0] mid_lo;
  logic [MID_W-1:0] mid_hi;
  cp_t              v0;
  cp_t              v1;

  assign rd_addr0 = item_i.base + ADDR_W'(item_i.mid);
  assign rd_addr1 = rd_addr0 + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (item_i.valid && item_i.wr_en) begin
        mem[item_i.wr_addr] <= item_i.wr_word;
      end
      rd0_r <= mem[rd_addr0];
      rd1_r <= mem[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (adv) begin
      item_r <= item_i;
    end
  end

  assign v0     = rd0_r[CP_W-1:0];
  assign v1     = rd1_r[CP_W-1:0];
  assign mid_lo = (MID_W'(item_r.lo) + MID_W'(item_r.mid)) >> 1;
  assign mid_hi = (MID_W'(item_r.mid) + MID_W'(1) + MID_W'(item_r.hi)) >> 1;

  always_comb begin
    item_o = item_r;
    if (item_r.valid && item_r.is_query && !item_r.done) begin
      if (item_r.lo < item_r.hi) begin
        if (item_r.cp < v0) begin
          item_o.hi  = item_r.mid;
          item_o.mid = mid_lo[IDX_W-1:0];
        end else if (item_r.cp == v0) begin
          item_o.done = 1'b1;
          item_o.res  = 1'b1;
        end else if (item_r.cp >= v1) begin
          item_o.lo  = IDX_W'(item_r.mid + IDX_W'(1));
          item_o.mid = mid_hi[IDX_W-1:0];
        end else begin
          item_o.done = 1'b1;
          item_o.res  = rd0_r[MARK_BIT];
        end
      end else begin
        item_o.done = 1'b1;
        item_o.res  = 1'b0;
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rlcm_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CP_MAX = (1 << CP_W) - 1;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam cp_t CP_TOP = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIST0_COUNT = 0,
    REG_LIST1_COUNT = 1,
    REG_LIST2_COUNT = 2,
    REG_LIST3_COUNT = 3
  } count_reg_e;

  localparam count_reg_e COUNT_REG [NUM_LISTS] = '{
    REG_LIST0_COUNT, REG_LIST1_COUNT, REG_LIST2_COUNT, REG_LIST3_COUNT
  };

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_COUNT} row_kind_e;

  typedef struct packed {
    logic             op;
    logic [SEL_W-1:0] sel;
    logic [EIDX_W-1:0] idx;
    cp_t              cp;
    logic             mark;
    logic             inv;
  } class_req_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [SEL_W-1:0]  sel;
    logic [EIDX_W-1:0] idx;
    cp_t               cp;
    logic              mark;
    logic              inv;
    logic [CNT_W-1:0]  cnt;
    logic              typed;
    logic              want;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_QUERY, 2'd0, 8'd0, 21'h000000, 1'b0, 1'b0, 9'd0, 1'b1, 1'b0},
    '{ROW_QUERY, 2'd3, 8'd0, 21'h1FFFFF, 1'b0, 1'b1, 9'd0, 1'b1, 1'b1},
    '{ROW_WRITE, 2'd0, 8'd0, 21'h000041, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_WRITE, 2'd0, 8'd1, 21'h00005A, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_WRITE, 2'd0, 8'd2, 21'h000061, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_WRITE, 2'd0, 8'd3, 21'h00007A, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_WRITE, 2'd0, 8'd4, 21'h10FFFF, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h000041, 1'b0, 1'b0, 9'd0, 1'b1, 1'b0},
    '{ROW_COUNT, 2'd0, 8'd0, 21'h000000, 1'b0, 1'b0, 9'd5, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h000040, 1'b0, 1'b0, 9'd0, 1'b1, 1'b0},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h000041, 1'b0, 1'b1, 9'd0, 1'b1, 1'b0},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h000050, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h00005B, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h10FFFE, 1'b0, 1'b1, 9'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h10FFFF, 1'b0, 1'b0, 9'd0, 1'b1, 1'b1},
    '{ROW_QUERY, 2'd0, 8'd0, 21'h1FFFFF, 1'b0, 1'b0, 9'd0, 1'b1, 1'b0},
    '{ROW_WRITE, 2'd1, 8'd0, 21'h000300, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_WRITE, 2'd1, 8'd1, 21'h000100, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_WRITE, 2'd1, 8'd2, 21'h000200, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_COUNT, 2'd1, 8'd0, 21'h000000, 1'b0, 1'b0, 9'd3, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd1, 8'd0, 21'h000250, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd1, 8'd0, 21'h000300, 1'b0, 1'b0, 9'd0, 1'b1, 1'b1},
    '{ROW_WRITE, 2'd2, 8'd0, 21'h000000, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_WRITE, 2'd2, 8'd1, 21'h1FFFFF, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_COUNT, 2'd2, 8'd0, 21'h000000, 1'b0, 1'b0, 9'd2, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd2, 8'd0, 21'h0ABCDE, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 2'd2, 8'd0, 21'h1FFFFF, 1'b0, 1'b1, 9'd0, 1'b1, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0] cfg_data;

  rlcm_in_if  in_ch ();
  rlcm_out_if out_ch ();

  range_list_class_membership_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cp_t              entry_cp   [NUM_LISTS][LIST_DEPTH];
  logic             entry_mark [NUM_LISTS][LIST_DEPTH];
  bit               entry_set  [NUM_LISTS][LIST_DEPTH];
  logic [CNT_W-1:0] list_cnt   [NUM_LISTS];
  logic [CNT_W-1:0] next_cnt   [NUM_LISTS];
  logic             member_q   [$];
  class_req_t       entry_writes [$];

  int  cycles;
  int  err_cnt;
  int  n_writes;
  int  n_queries;
  int  n_results;
  int  n_settings;
  int  max_cnt_seen;
  int  rnd_items;
  int  stall_left;
  bit  no_gap;
  bit  no_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_count(input int sel);
    return (list_cnt[sel] > LIST_DEPTH) ? LIST_DEPTH : int'(list_cnt[sel]);
  endfunction

  function automatic bit list_ready(input int sel);
    int n;
    n = eff_count(sel);
    for (int i = 0; i < n; i++) begin
      if (!entry_set[sel][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int written_prefix(input int sel);
    int p;
    p = 0;
    while (p < LIST_DEPTH && entry_set[sel][p]) p++;
    return p;
  endfunction

  // binary search over the sorted entries; a marked entry covers up to its successor
  function automatic logic class_hit(input int sel, input cp_t cp);
    int   n;
    int   lo;
    int   hi;
    int   mid;
    cp_t  v;
    n = eff_count(sel);
    if (n == 0) return 1'b0;
    if (cp <= entry_cp[sel][0]) return cp == entry_cp[sel][0];
    if (cp >= entry_cp[sel][n-1]) return cp == entry_cp[sel][n-1];
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      v = entry_cp[sel][mid];
      if (cp < v) begin
        hi = mid;
      end else if (cp == v) begin
        return 1'b1;
      end else if (cp >= entry_cp[sel][mid+1]) begin
        lo = mid + 1;
      end else begin
        return entry_mark[sel][mid];
      end
    end
    return 1'b0;
  endfunction

  function automatic cp_t pick_probe(input int sel);
    int  n;
    int  i;
    int  k;
    cp_t v;
    cp_t w;
    n = eff_count(sel);
    k = $urandom_range(0, 9);
    if (n == 0 || k == 0) return cp_t'($urandom);
    if (k == 1) return $urandom_range(0, 1) ? CP_TOP : cp_t'(0);
    i = $urandom_range(0, n - 1);
    v = entry_cp[sel][i];
    if (k <= 4 && i < n - 1) begin
      w = entry_cp[sel][i+1];
      if (w > v) return cp_t'($urandom_range(int'(w), int'(v)));
    end
    return cp_t'(v + $urandom_range(0, 2) - 1);
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  task automatic send(input class_req_t r, input bit typed, input logic want);
    int g;
    g = no_gap ? 0 : pick_idle();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= r.op;
    in_ch.list_select <= r.sel;
    in_ch.entry_index <= r.idx;
    in_ch.code_point  <= r.cp;
    in_ch.range_start <= r.mark;
    in_ch.invert      <= r.inv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (r.op == OP_WRITE) begin
      entry_cp[r.sel][r.idx]   = r.cp;
      entry_mark[r.sel][r.idx] = r.mark;
      entry_set[r.sel][r.idx]  = 1'b1;
      n_writes++;
    end else begin
      member_q.push_back(typed ? want : (class_hit(int'(r.sel), r.cp) ^ r.inv));
      n_queries++;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (member_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_counts();
    for (int k = 0; k < NUM_LISTS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= COUNT_REG[k];
      cfg_data  <= next_cnt[k];
      @(posedge clk);
      list_cnt[k] = next_cnt[k];
      if (int'(next_cnt[k]) > max_cnt_seen) max_cnt_seen = int'(next_cnt[k]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic queue_sorted(input int sel, input int n);
    int         stepmax;
    int         v;
    class_req_t r;
    stepmax = $urandom_range(0, 1) ? 3 : 4000;
    v = $urandom_range(0, CP_MAX - n * stepmax);
    for (int i = 0; i < n; i++) begin
      r.op   = OP_WRITE;
      r.sel  = SEL_W'(sel);
      r.idx  = EIDX_W'(i);
      r.cp   = cp_t'(v);
      r.mark = 1'($urandom_range(0, 1));
      r.inv  = 1'($urandom_range(0, 1));
      entry_writes.push_back(r);
      v += $urandom_range(1, stepmax);
    end
  endtask

  task automatic run_phase(input int ph, input int full_sel);
    int         n;
    int         p;
    int         nq;
    int         choice;
    int         elig [$];
    class_req_t r;
    settle();
    no_gap   = ($urandom_range(0, 4) == 0);
    no_stall = ($urandom_range(0, 4) == 0);
    for (int s = 0; s < NUM_LISTS; s++) begin
      choice = $urandom_range(0, 19);
      if (s == full_sel && ph == 0) begin
        queue_sorted(s, LIST_DEPTH);
        next_cnt[s] = CNT_W'(CNT_MAX);
      end else if (s == full_sel && ph == 1) begin
        next_cnt[s] = CNT_W'(LIST_DEPTH);
      end else if (choice < 12) begin
        n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 10);
        queue_sorted(s, n);
        next_cnt[s] = CNT_W'(n);
      end else if (choice < 14) begin
        next_cnt[s] = '0;
      end else if (choice < 17) begin
        p = written_prefix(s);
        next_cnt[s] = (p == LIST_DEPTH) ? CNT_W'($urandom_range(LIST_DEPTH, CNT_MAX))
                                        : CNT_W'($urandom_range(0, p));
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          r.op   = OP_WRITE;
          r.sel  = SEL_W'(s);
          r.idx  = EIDX_W'(i);
          r.cp   = cp_t'($urandom);
          r.mark = 1'($urandom_range(0, 1));
          r.inv  = 1'($urandom_range(0, 1));
          entry_writes.push_back(r);
        end
        next_cnt[s] = CNT_W'(n);
      end
    end
    load_counts();
    nq = $urandom_range(30, 90);
    while (entry_writes.size() > 0 || nq > 0) begin
      elig.delete();
      for (int s = 0; s < NUM_LISTS; s++) begin
        if (list_ready(s)) elig.push_back(s);
      end
      if (entry_writes.size() > 0 &&
          (nq == 0 || elig.size() == 0 || $urandom_range(0, 4) != 0)) begin
        send(entry_writes.pop_front(), 1'b0, 1'b0);
      end else if ($urandom_range(0, 11) == 0) begin
        // stray write: may break the order of a list in use
        r.op   = OP_WRITE;
        r.sel  = SEL_W'($urandom_range(0, NUM_LISTS - 1));
        r.idx  = EIDX_W'($urandom_range(0, LIST_DEPTH - 1));
        r.cp   = cp_t'($urandom);
        r.mark = 1'($urandom_range(0, 1));
        r.inv  = 1'($urandom_range(0, 1));
        send(r, 1'b0, 1'b0);
      end else begin
        r.op   = OP_QUERY;
        r.sel  = SEL_W'(elig[$urandom_range(0, elig.size() - 1)]);
        r.idx  = EIDX_W'($urandom_range(0, LIST_DEPTH - 1));
        r.cp   = pick_probe(int'(r.sel));
        r.mark = 1'($urandom_range(0, 1));
        r.inv  = 1'($urandom_range(0, 1));
        send(r, 1'b0, 1'b0);
        nq--;
      end
      rnd_items++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycles,
               member_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin : result_side
    logic want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      if (member_q.size() == 0) begin
        report_mismatch($sformatf("is_member=%b transfer with no query pending",
                                  out_ch.is_member));
      end else begin
        want = member_q.pop_front();
        if (out_ch.is_member !== want)
          report_mismatch($sformatf("is_member=%b, expected %b (result %0d)",
                                    out_ch.is_member, want, n_results));
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!no_stall && $urandom_range(0, 3) == 0) stall_left <= pick_idle();
    end
  end

  initial begin
    class_req_t r;
    int         full_sel;
    int         ph;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_WRITE;
    in_ch.list_select = '0;
    in_ch.entry_index = '0;
    in_ch.code_point  = '0;
    in_ch.range_start = 1'b0;
    in_ch.invert      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_LIST0_COUNT;
    cfg_data          = '0;
    rst_n             = 1'b0;
    no_gap            = 1'b0;
    no_stall          = 1'b0;
    for (int k = 0; k < NUM_LISTS; k++) list_cnt[k] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].kind == ROW_COUNT) begin
        settle();
        foreach (next_cnt[k]) next_cnt[k] = list_cnt[k];
        next_cnt[DIR_TAB[i].sel] = DIR_TAB[i].cnt;
        load_counts();
      end else begin
        r.op   = (DIR_TAB[i].kind == ROW_QUERY) ? OP_QUERY : OP_WRITE;
        r.sel  = DIR_TAB[i].sel;
        r.idx  = DIR_TAB[i].idx;
        r.cp   = DIR_TAB[i].cp;
        r.mark = DIR_TAB[i].mark;
        r.inv  = DIR_TAB[i].inv;
        send(r, DIR_TAB[i].typed, DIR_TAB[i].want);
      end
    end

    full_sel = $urandom_range(0, NUM_LISTS - 1);
    ph = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      run_phase(ph, full_sel);
      ph++;
    end
    settle();

    $display("Ran %0d entry writes and %0d queries (%0d results) across %0d count settings,",
             n_writes, n_queries, n_results, n_settings);
    $display("with lists up to %0d entries, counts up to %0d and random stalls both sides.",
             LIST_DEPTH, max_cnt_seen);
    if (err_cnt == 0 && member_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_cnt, member_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
